### hw/rtl/prsld_pkg.sv
// prsld_pkg: shared types and constants of the palette rle sprite line decoder
// no dependencies; imported by the front, queue, back and top level modules
`default_nettype none

package prsld_pkg;

    localparam int MAX_LINE_WIDTH  = 4096;
    localparam int PALETTE_ENTRIES = 256;

    localparam logic [12:0] MAX_WIDTH_W      = 13'(MAX_LINE_WIDTH);
    localparam logic [12:0] LINE_WIDTH_RESET = 13'd4096;

    // input op codes
    localparam logic [1:0] OP_PAL_WRITE = 2'd0;
    localparam logic [1:0] OP_LINE      = 2'd1;
    localparam logic [1:0] OP_DATA      = 2'd2;

    // flag byte classes, top two bits
    localparam logic [1:0] FLAG_ALPHA = 2'b00;
    localparam logic [1:0] FLAG_LIT   = 2'b01;
    localparam logic [1:0] FLAG_REP   = 2'b10;
    localparam logic [1:0] FLAG_SKIP  = 2'b11;

    localparam logic [4:0] ALPHA_FULL = 5'h1F;

    typedef enum logic [2:0] {
        PH_FLAG,
        PH_APIX_INDEX,
        PH_ARUN_ALPHA,
        PH_ARUN_INDEX,
        PH_LIT_INDEX,
        PH_REP_INDEX
    } t_phase;

    typedef enum logic [1:0] {
        CMD_PAL,
        CMD_LINE,
        CMD_EMIT
    } t_cmd_kind;

    // one queued action for the back end
    typedef struct packed {
        t_cmd_kind   kind;
        logic [5:0]  count;
        logic [4:0]  alpha;
        logic        zero;
        logic [7:0]  index;
        logic [15:0] rgb;
    } t_cmd;

endpackage

`default_nettype wire

### hw/rtl/prsld_if.sv
// prsld channel interfaces: coded input, pixel output and width write port
// no dependencies; used by the front, back and top level modules
`default_nettype none

interface prsld_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  code_byte;
    logic [7:0]  palette_slot;
    logic [15:0] palette_rgb565;

    modport source (output valid, output op, output code_byte, output palette_slot,
                    output palette_rgb565, input ready);
    modport sink   (input valid, input op, input code_byte, input palette_slot,
                    input palette_rgb565, output ready);
endinterface

interface prsld_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_column;
    logic [31:0] pixel_argb;
    logic        run_last;

    modport source (output valid, output pixel_column, output pixel_argb,
                    output run_last, input ready);
    modport sink   (input valid, input pixel_column, input pixel_argb,
                    input run_last, output ready);
endinterface

interface prsld_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] line_width;

    modport source (output valid, output line_width, input ready);
    modport sink   (input valid, input line_width, output ready);
endinterface

`default_nettype wire

### hw/rtl/palette_rle_sprite_line_decoder_top.sv
// palette_rle_sprite_line_decoder_top: top level of the sprite line decoder
// depends on prsld_pkg, prsld_if, prsld_front, prsld_queue and prsld_back
//
// usage
//   i_in carries items: palette writes (op 0), line starts (op 1) and coded
//   bytes (op 2); op 3 is accepted and ignored. o_out carries pixels with their
//   column and a run_last mark on the last pixel that one coded byte causes.
//   i_cfg writes the line width and is always ready; the user must write it
//   only while idle, which the block itself does not enforce.
// throughput
//   the front takes one item per cycle while the command queue has room.
//   palette writes and line starts are taken by the back end in a single pop;
//   a byte that emits pixels first reads the palette, then sends its pixels
//   in turn unless o_out stalls; a run starting at the line end sends nothing.
//   the first pixel passes the queue, palette read and output registers;
//   bytes that only update the parse state stay in the front and push nothing.
// reset
//   synchronous active-low; clears parse state, queue, column and output valid.
//   line width returns to 4096. palette contents are undefined until written.
// stalls
//   a stalled receiver freezes the pixel run; the queue then fills and the
//   front deasserts ready, without any pixel being lost or repeated.
`default_nettype none

module palette_rle_sprite_line_decoder_top
    import prsld_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    prsld_in_if.sink     i_in,
    prsld_cfg_if.sink    i_cfg,
    prsld_out_if.source  o_out
);

    // line width register, written through the config channel
    logic [12:0] r_line_width;

    // front to queue
    logic  push;
    t_cmd  push_cmd;
    logic  full;

    // queue to back
    logic  head_valid;
    t_cmd  head_cmd;
    logic  pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
        end else if (i_cfg.valid) begin
            r_line_width <= i_cfg.line_width;
        end
    end

    // parser: classifies bytes and issues palette, line and emit commands
    prsld_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // decouples parsing from pixel emission
    prsld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head_cmd)
    );

    // palette lookup, column tracking and output register
    prsld_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_width (r_line_width),
        .i_head_valid (head_valid),
        .i_head       (head_cmd),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

### hw/rtl/prsld_front.sv
// prsld_front: accepts input items, tracks the flag parse state, issues commands
// depends on prsld_pkg and prsld_in_if
`default_nettype none

module prsld_front
    import prsld_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    prsld_in_if.sink   i_in,
    input  wire        i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_phase     r_phase, n_phase;
    logic [5:0] r_count, n_count;
    logic [4:0] r_alpha, n_alpha;
    logic       accept;
    logic [7:0] b;
    logic [5:0] count_dec;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.code_byte;
    assign count_dec  = r_count - 6'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAG;
            r_count <= '0;
            r_alpha <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_alpha <= n_alpha;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_alpha     = r_alpha;
        o_push      = 1'b0;
        o_cmd       = '0;
        o_cmd.kind  = CMD_EMIT;
        o_cmd.index = b;
        if (accept) begin
            unique case (i_in.op)
                OP_PAL_WRITE: begin
                    o_push      = 1'b1;
                    o_cmd.kind  = CMD_PAL;
                    o_cmd.index = i_in.palette_slot;
                    o_cmd.rgb   = i_in.palette_rgb565;
                end
                OP_LINE: begin
                    o_push     = 1'b1;
                    o_cmd.kind = CMD_LINE;
                    n_phase    = PH_FLAG;
                    n_count    = '0;
                    n_alpha    = '0;
                end
                OP_DATA: begin
                    unique case (r_phase)
                        PH_FLAG: begin
                            unique case (b[7:6])
                                FLAG_ALPHA: begin
                                    if (b[5]) begin
                                        n_alpha = b[4:0];
                                        n_phase = PH_APIX_INDEX;
                                    end else if (b != 8'd0) begin
                                        n_count = {1'b0, b[4:0]};
                                        n_phase = PH_ARUN_ALPHA;
                                    end
                                end
                                FLAG_LIT: begin
                                    n_count = b[5:0];
                                    if (b[5:0] != 6'd0) begin
                                        n_phase = PH_LIT_INDEX;
                                    end
                                end
                                FLAG_REP: begin
                                    n_count = b[5:0];
                                    n_phase = PH_REP_INDEX;
                                end
                                FLAG_SKIP: begin
                                    // transparent run goes out straight away
                                    o_push      = (b[5:0] != 6'd0);
                                    o_cmd.count = b[5:0];
                                    o_cmd.zero  = 1'b1;
                                end
                                default: ;
                            endcase
                        end
                        PH_APIX_INDEX: begin
                            o_push      = 1'b1;
                            o_cmd.count = 6'd1;
                            o_cmd.alpha = r_alpha;
                            n_phase     = PH_FLAG;
                        end
                        PH_ARUN_ALPHA: begin
                            n_alpha = b[4:0];
                            n_phase = PH_ARUN_INDEX;
                        end
                        PH_ARUN_INDEX: begin
                            o_push      = (r_count != 6'd0);
                            o_cmd.count = r_count;
                            o_cmd.alpha = r_alpha;
                            n_count     = '0;
                            n_phase     = PH_FLAG;
                        end
                        PH_LIT_INDEX: begin
                            o_push      = 1'b1;
                            o_cmd.count = 6'd1;
                            o_cmd.alpha = ALPHA_FULL;
                            n_count     = count_dec;
                            if (count_dec == 6'd0) begin
                                n_phase = PH_FLAG;
                            end
                        end
                        PH_REP_INDEX: begin
                            o_push      = (r_count != 6'd0);
                            o_cmd.count = r_count;
                            o_cmd.alpha = ALPHA_FULL;
                            n_count     = '0;
                            n_phase     = PH_FLAG;
                        end
                        default: begin
                            n_phase = PH_FLAG;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/prsld_queue.sv
// prsld_queue: small register queue of commands between front and back ends
// depends on prsld_pkg
`default_nettype none

module prsld_queue
    import prsld_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    input  wire   i_pop,
    output logic  o_valid,
    output t_cmd  o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/prsld_back.sv
// prsld_back: palette memory, column tracking and pixel run emission
// depends on prsld_pkg and prsld_out_if
`default_nettype none

module prsld_back
    import prsld_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire [12:0]   i_line_width,
    input  wire          i_head_valid,
    input  t_cmd         i_head,
    output logic         o_pop,
    prsld_out_if.source  o_out
);

    logic [15:0] r_mem [PALETTE_ENTRIES];
    logic [15:0] r_rd_data;
    logic        r_run_active;
    logic [5:0]  r_left;
    logic [4:0]  r_alpha;
    logic        r_zero;
    logic [12:0] r_column;
    logic        r_out_valid;
    logic [11:0] r_out_col;
    logic [31:0] r_out_argb;
    logic        r_out_last;

    logic [12:0] eff_w;
    logic        col_ok;
    logic        slot_free;
    logic        fire;
    logic        last;
    logic [31:0] pixel;

    function automatic logic [31:0] expand_colour(input logic [15:0] w);
        expand_colour = {8'h00, w[15:11], 3'b000, w[10:5], 2'b00, w[4:0], 3'b000};
    endfunction

    assign eff_w     = (i_line_width < MAX_WIDTH_W) ? i_line_width : MAX_WIDTH_W;
    assign col_ok    = (r_column < eff_w);
    assign slot_free = !r_out_valid || o_out.ready;
    assign fire      = r_run_active && col_ok && (r_left != 6'd0) && slot_free;
    assign last      = (r_left == 6'd1) || ((r_column + 13'd1) == eff_w);
    assign o_pop     = i_head_valid && !r_run_active;
    assign pixel     = r_zero ? 32'd0
                              : (expand_colour(r_rd_data) | {r_alpha, 27'd0});

    assign o_out.valid        = r_out_valid;
    assign o_out.pixel_column = r_out_col;
    assign o_out.pixel_argb   = r_out_argb;
    assign o_out.run_last     = r_out_last;

    // palette write port
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.kind == CMD_PAL)) begin
            r_mem[i_head.index] <= i_head.rgb;
        end
    end

    // palette read port, data held for the whole run
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.kind == CMD_EMIT)) begin
            r_rd_data <= r_mem[i_head.index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_col  <= r_column[11:0];
            r_out_argb <= pixel;
            r_out_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_active <= 1'b0;
            r_left       <= '0;
            r_alpha      <= '0;
            r_zero       <= 1'b0;
            r_column     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (o_pop) begin
                unique case (i_head.kind)
                    CMD_LINE: begin
                        r_column <= '0;
                    end
                    CMD_EMIT: begin
                        r_run_active <= 1'b1;
                        r_left       <= i_head.count;
                        r_alpha      <= i_head.alpha;
                        r_zero       <= i_head.zero;
                    end
                    default: ;
                endcase
            end else if (fire) begin
                r_left   <= r_left - 6'd1;
                r_column <= r_column + 13'd1;
                if (last) begin
                    r_run_active <= 1'b0;
                end
            end else if (r_run_active && (!col_ok || (r_left == 6'd0))) begin
                // line end reached or nothing left: run is over
                r_run_active <= 1'b0;
            end
        end
    end

    a_emit_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_head.kind == CMD_EMIT)) |=> r_run_active)
        else $error("emit command did not start a run");

    a_stall_holds_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_active && r_out_valid && !o_out.ready) |=> $stable(r_left))
        else $error("run advanced while output stalled");

    a_fire_moves_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_column == $past(r_column) + 13'd1) && r_out_valid)
        else $error("emitted pixel did not advance the column");

endmodule

`default_nettype wire
